/* rtl/core/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that a property holds, with reset as the disable condition.
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checks that a condition never holds, with reset as the disable condition.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`endif

/* rtl/core/bces_pkg.sv */
// Package with the types, codes and constants of the execute unit.
package bces_pkg;

  localparam int unsigned XlenW    = 32;
  localparam int unsigned RegIdxW  = 5;
  localparam int unsigned CmdW     = 6;
  localparam int unsigned ImmW     = 16;
  localparam int unsigned QDepthDefault = 2;

  localparam logic [31:0] PcMaskUser = 32'h7FFF_FFFC;
  localparam logic [31:0] SuperBit   = 32'h8000_0000;
  localparam logic [31:0] VecReset   = 32'h8000_0000;
  localparam logic [31:0] VecIllop   = 32'h8000_0004;
  localparam logic [31:0] VecClk     = 32'h8000_0008;
  localparam logic [31:0] VecKbd     = 32'h8000_000C;
  localparam logic [4:0]  ZeroReg    = 5'd31;
  localparam logic [4:0]  XpReg      = 5'd30;

  // Dense command codes.
  localparam logic [5:0] CmdAluLast = 6'd25;
  localparam logic [5:0] CmdJmp     = 6'd26;
  localparam logic [5:0] CmdBt      = 6'd27;
  localparam logic [5:0] CmdBf      = 6'd28;
  localparam logic [5:0] CmdLd      = 6'd29;
  localparam logic [5:0] CmdSt      = 6'd30;
  localparam logic [5:0] CmdLdr     = 6'd31;
  localparam logic [5:0] CmdCallout = 6'd32;

  // Callout codes.
  localparam logic [15:0] CallHalt  = 16'd0;
  localparam logic [15:0] CallRdChr = 16'd1;
  localparam logic [15:0] CallWrChr = 16'd2;

  typedef enum logic [3:0] {
    AluAdd, AluAnd, AluMul, AluDiv, AluOr, AluShl, AluShr, AluSra,
    AluSub, AluXor, AluCmpeq, AluCmple, AluCmplt
  } alu_op_e;

  typedef enum logic [2:0] {
    ClsAlu, ClsBranch, ClsLd, ClsSt, ClsLdr, ClsCallout, ClsIllegal
  } cls_e;

  // Classified instruction as handed from front to back.
  typedef struct packed {
    cls_e          cls;
    alu_op_e       alu_op;
    logic          use_imm;
    logic          is_jmp;
    logic          is_bt;
    logic [4:0]    src_a;
    logic [4:0]    src_b;
    logic [4:0]    dest_c;
    logic [31:0]   imm;
    logic [31:0]   load_word;
    logic [7:0]    char_in;
    logic          clk_irq;
    logic          kbd_irq;
  } op_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] mem_addr;
    logic [31:0] mem_wdata;
    logic        char_out_valid;
    logic [7:0]  char_out;
    logic        halted;
  } res_t;

  typedef struct packed {
    logic [5:0]  command;
    logic [4:0]  src_a;
    logic [4:0]  src_b;
    logic [4:0]  dest_c;
    logic [15:0] immediate;
    logic [31:0] load_word;
    logic [7:0]  char_in;
    logic        clk_irq;
    logic        kbd_irq;
  } item_t;

endpackage

/* rtl/core/bces_if.sv */
// Valid/ready channel interface carrying one word of a given type.
interface bces_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/bces_ram.sv */
// Generic single write port RAM with two registered read ports.
module bces_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr0_i,
  input  logic [$clog2(Depth)-1:0] raddr1_i,
  output logic [Width-1:0]         rdata0_o,
  output logic [Width-1:0]         rdata1_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata0_o <= mem_q[raddr0_i];
    rdata1_o <= mem_q[raddr1_i];
  end
endmodule

/* rtl/core/bces_front.sv */
// Front end: takes words, classifies the command and queues the result.
module bces_front #(
  parameter int unsigned QDepth = bces_pkg::QDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bces_pkg::item_t     item_i,
  input  logic                item_valid_i,
  output logic                item_ready_o,
  output bces_pkg::op_t       op_o,
  output logic                op_valid_o,
  input  logic                op_pop_i
);
  import bces_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  op_t              q_mem_q [QDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [PtrW:0]    cnt_q, cnt_d;
  op_t              cls_op;
  logic             push;

  // Classification of the incoming command.
  always_comb begin
    cls_op           = '0;
    cls_op.src_a     = item_i.src_a;
    cls_op.src_b     = item_i.src_b;
    cls_op.dest_c    = item_i.dest_c;
    cls_op.imm       = {{(XlenW-ImmW){item_i.immediate[ImmW-1]}}, item_i.immediate};
    cls_op.load_word = item_i.load_word;
    cls_op.char_in   = item_i.char_in;
    cls_op.clk_irq   = item_i.clk_irq;
    cls_op.kbd_irq   = item_i.kbd_irq;
    cls_op.use_imm   = item_i.command[0];
    cls_op.alu_op    = alu_op_e'(item_i.command[4:1]);
    cls_op.is_jmp    = (item_i.command == CmdJmp);
    cls_op.is_bt     = (item_i.command == CmdBt);
    priority if (item_i.command <= CmdAluLast) begin
      cls_op.cls = ClsAlu;
    end else if (item_i.command == CmdJmp || item_i.command == CmdBt ||
                 item_i.command == CmdBf) begin
      cls_op.cls = ClsBranch;
    end else if (item_i.command == CmdLd) begin
      cls_op.cls = ClsLd;
    end else if (item_i.command == CmdSt) begin
      cls_op.cls = ClsSt;
    end else if (item_i.command == CmdLdr) begin
      cls_op.cls = ClsLdr;
    end else if (item_i.command == CmdCallout) begin
      cls_op.cls = ClsCallout;
    end else begin
      cls_op.cls = ClsIllegal;
    end
  end

  assign item_ready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign push         = item_valid_i && item_ready_o;
  assign op_valid_o   = (cnt_q != '0);
  assign op_o         = q_mem_q[rptr_q];

  // Queue pointers.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(QDepth-1)) ? '0 : wptr_q + 1'b1;
    end
    if (op_pop_i) begin
      rptr_d = (rptr_q == PtrW'(QDepth-1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(op_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wptr_q] <= cls_op;
    end
  end
endmodule

/* rtl/core/bces_div.sv */
// Iterative signed divider, one quotient bit a cycle; divide by zero gives 0.
module bces_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] quot_o
);
  logic [31:0] rem_q, rem_d, quo_q, quo_d, div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d, zero_q, zero_d;
  logic [32:0] trial;

  assign trial  = {rem_q, quo_q[31]} - {1'b0, div_q};
  assign done_o = busy_q && (cnt_q == 6'd0);
  assign quot_o = zero_q ? '0 : (neg_q ? (32'd0 - quo_q) : quo_q);

  // Restoring division over magnitudes.
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    busy_d = busy_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = a_i[31] ? (32'd0 - a_i) : a_i;
      div_d  = b_i[31] ? (32'd0 - b_i) : b_i;
      neg_d  = a_i[31] ^ b_i[31];
      zero_d = (b_i == '0);
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q && cnt_q != 6'd0) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
    end else if (done_o) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    div_q  <= div_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end
endmodule

/* rtl/core/bces_back.sv */
// Back end: reads registers, executes, takes interrupts and writes back.
module bces_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bces_pkg::op_t   op_i,
  input  logic            op_valid_i,
  output logic            op_pop_o,
  output bces_pkg::res_t  res_o,
  output logic            res_valid_o,
  input  logic            res_ready_i
);
  import bces_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StExec = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StWb   = 3'd4;

  logic [2:0]  st_q, st_d;
  logic [31:0] pc_q;
  logic        halt_q, halt_d, clkp_q, clkp_d;
  logic        outv_q, outv_d;
  res_t        out_q, out_d, halt_res;
  op_t         op_q;
  logic [31:0] rdata_a, rdata_b, a_v, b_v;
  logic [4:0]  raddr_b;
  logic [31:0] alu_y_d, mul_p;
  logic        we, we2;
  logic [4:0]  waddr;
  logic [31:0] wdata;
  logic        we_q, we_d, xp_q, xp_d;
  logic [4:0]  wa_q, wa_d;
  logic [31:0] wd_q, wd_d, xd_q, xd_d;
  logic        div_start, div_done;
  logic [31:0] div_y;
  logic [31:0] pc4, mask, tgt, fpc;
  logic        illegal, pend;
  logic        slt;

  // R31 reads as zero; rb port reads rc for a store and R0 for callouts.
  always_comb begin
    priority if (op_q.cls == ClsSt) begin
      raddr_b = op_q.dest_c;
    end else if (op_q.cls == ClsCallout) begin
      raddr_b = 5'd0;
    end else begin
      raddr_b = op_q.src_b;
    end
  end

  bces_ram #(.Width(XlenW), .Depth(32)) u_rf (
    .clk_i    (clk_i),
    .we_i     (we),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr0_i (op_q.src_a),
    .raddr1_i (raddr_b),
    .rdata0_o (rdata_a),
    .rdata1_o (rdata_b)
  );

  // Reset only clears the flags; all-zero register file is tracked per entry.
  logic [31:0] rvalid_q, rvalid_d;
  assign a_v = (op_q.src_a == ZeroReg || !rvalid_q[op_q.src_a]) ? '0 : rdata_a;
  always_comb begin
    b_v = (raddr_b == ZeroReg || !rvalid_q[raddr_b]) ? '0 : rdata_b;
    if (op_q.cls == ClsAlu && op_q.use_imm) begin
      b_v = op_q.imm;
    end
  end

  assign slt   = (a_v ^ SuperBit) < (b_v ^ SuperBit);
  assign mul_p = a_v * b_v;

  always_comb begin
    unique case (op_q.alu_op)
      AluAdd:   alu_y_d = a_v + b_v;
      AluAnd:   alu_y_d = a_v & b_v;
      AluMul:   alu_y_d = mul_p;
      AluOr:    alu_y_d = a_v | b_v;
      AluShl:   alu_y_d = a_v << b_v[4:0];
      AluShr:   alu_y_d = a_v >> b_v[4:0];
      AluSra:   alu_y_d = 32'($signed(a_v) >>> b_v[4:0]);
      AluSub:   alu_y_d = a_v - b_v;
      AluXor:   alu_y_d = a_v ^ b_v;
      AluCmpeq: alu_y_d = {31'd0, a_v == b_v};
      AluCmple: alu_y_d = {31'd0, (a_v == b_v) || slt};
      AluCmplt: alu_y_d = {31'd0, slt};
      default:  alu_y_d = '0;
    endcase
  end

  assign div_start = (st_q == StExec) && op_q.cls == ClsAlu && op_q.alu_op == AluDiv;

  bces_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (a_v),
    .b_i     (b_v),
    .done_o  (div_done),
    .quot_o  (div_y)
  );

  // Control flow, memory and callout effects of one instruction.
  assign pc4  = pc_q + 32'd4;
  assign mask = PcMaskUser | (pc4 & SuperBit);
  assign tgt  = pc4 + {op_q.imm[29:0], 2'b00};

  always_comb begin
    out_d   = '0;
    fpc     = pc4;
    illegal = 1'b0;
    we_d    = 1'b0;
    wa_d    = op_q.dest_c;
    wd_d    = '0;
    halt_d  = halt_q;
    clkp_d  = clkp_q | op_q.clk_irq;
    unique case (op_q.cls)
      ClsAlu: begin
        we_d = 1'b1;
        wd_d = alu_y_d;
      end
      ClsBranch: begin
        we_d = 1'b1;
        wd_d = pc4;
        if (op_q.is_jmp) begin
          fpc = a_v & mask;
        end else if (op_q.is_bt == (a_v != '0)) begin
          fpc = tgt & mask;
        end
      end
      ClsLd: begin
        out_d.mem_read = 1'b1;
        out_d.mem_addr = a_v + op_q.imm;
        we_d = 1'b1;
        wd_d = op_q.load_word;
      end
      ClsSt: begin
        out_d.mem_write = 1'b1;
        out_d.mem_addr  = a_v + op_q.imm;
        out_d.mem_wdata = b_v;
      end
      ClsLdr: begin
        out_d.mem_read = 1'b1;
        out_d.mem_addr = tgt;
        we_d = 1'b1;
        wd_d = op_q.load_word;
      end
      ClsCallout: begin
        if (pc4[31]) begin
          if (op_q.imm[15:0] == CallHalt && op_q.imm[31:16] == '0) begin
            halt_d = 1'b1;
          end else if (op_q.imm == {16'd0, CallRdChr}) begin
            we_d = 1'b1;
            wa_d = 5'd0;
            wd_d = {24'd0, op_q.char_in};
          end else if (op_q.imm == {16'd0, CallWrChr}) begin
            out_d.char_out_valid = 1'b1;
            out_d.char_out       = b_v[7:0];
          end
        end else begin
          illegal = 1'b1;
        end
      end
      default: illegal = 1'b1;
    endcase
    xp_d = 1'b0;
    xd_d = '0;
    if (illegal) begin
      xp_d = 1'b1;
      xd_d = fpc;
      fpc  = VecIllop;
    end
    pend = clkp_d || op_q.kbd_irq;
    if (pend && !fpc[31]) begin
      xp_d = 1'b1;
      xd_d = fpc + 32'd4;
      fpc  = clkp_d ? VecClk : VecKbd;
      clkp_d = 1'b0;
    end
    if (we_d && wa_d == ZeroReg) begin
      we_d = 1'b0;
    end
    out_d.next_pc = fpc;
    out_d.halted  = halt_d;
  end

  // Answer of a halted unit: the current PC with only the halt flag set.
  always_comb begin
    halt_res         = '0;
    halt_res.next_pc = pc_q;
    halt_res.halted  = 1'b1;
  end

  // Write back: main result then XP, one per cycle.
  assign we    = (st_q == StWb) ? we_q : ((st_q == StIdle) && xp_q);
  assign waddr = (st_q == StWb) ? wa_q : XpReg;
  assign wdata = (st_q == StWb) ? ((op_q.cls == ClsAlu && op_q.alu_op == AluDiv) ?
                 div_y : wd_q) : xd_q;
  assign we2   = (st_q == StIdle) && xp_q;

  assign op_pop_o    = (st_q == StIdle) && op_valid_i && !outv_q && !xp_q;
  assign res_valid_o = outv_q;
  assign res_o       = out_q;

  always_comb begin
    st_d     = st_q;
    outv_d   = outv_q;
    rvalid_d = rvalid_q;
    if (outv_q && res_ready_i) begin
      outv_d = 1'b0;
    end
    // A halted unit answers the word straight away without effect.
    if ((op_pop_o && halt_q) || st_q == StWb) begin
      outv_d = 1'b1;
    end
    if (we) begin
      rvalid_d[waddr] = 1'b1;
    end
    unique case (st_q)
      StIdle: if (op_pop_o && !halt_q) st_d = StRead;
      StRead: st_d = StExec;
      StExec: st_d = div_start ? StDiv : StWb;
      StDiv:  if (div_done) st_d = StWb;
      StWb:   st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      pc_q     <= VecReset;
      halt_q   <= 1'b0;
      clkp_q   <= 1'b0;
      outv_q   <= 1'b0;
      xp_q     <= 1'b0;
      rvalid_q <= '0;
    end else begin
      st_q     <= st_d;
      outv_q   <= outv_d;
      rvalid_q <= rvalid_d;
      if (we2) begin
        xp_q <= 1'b0;
      end else if (st_q == StExec) begin
        xp_q <= xp_d;
      end
      if (st_q == StExec) begin
        pc_q   <= out_d.next_pc;
        halt_q <= halt_d;
        clkp_q <= clkp_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_pop_o) begin
      op_q <= op_i;
    end
    if (op_pop_o && halt_q) begin
      out_q <= halt_res;
    end else if (st_q == StExec) begin
      out_q <= out_d;
    end
    if (st_q == StExec) begin
      we_q  <= we_d;
      wa_q  <= wa_d;
      wd_q  <= wd_d;
      xd_q  <= xd_d;
    end
  end
endmodule

/* rtl/core/beta_cpu_execute_step_unit.sv */
// Top level of the Beta execute unit: front classifier, queue and back end.
//
//  channel | dir | payload
//  in_ch   | in  | command src_a src_b dest_c immediate load_word char_in clk_irq kbd_irq
//  out_ch  | out | next_pc mem_read mem_write mem_addr mem_wdata char_out_valid
//          |     |   char_out halted
//
// In the back end a word goes through pop, register read, execute, write back and
// result handoff before the next pop; an XP write overlaps the handoff. DIV adds a
// wait in the divider state, one quotient bit a cycle. A halted unit answers a word
// without executing it. A waiting result holds the back end until out_ch takes it.
// Reset sets PC to the reset vector, clears the flags and makes registers read zero.
// The front queue keeps taking words while the back end waits for out_ch, until full.
module beta_cpu_execute_step_unit #(
  parameter int unsigned QDepth = bces_pkg::QDepthDefault
) (
  input logic clk_i,
  input logic rst_ni,
  bces_if.sink   in_ch,
  bces_if.source out_ch
);
  import bces_pkg::*;
  `include "assert_macros.svh"

  op_t  op;
  logic op_valid, op_pop;

  bces_front #(.QDepth(QDepth)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (in_ch.data),
    .item_valid_i (in_ch.valid),
    .item_ready_o (in_ch.ready),
    .op_o         (op),
    .op_valid_o   (op_valid),
    .op_pop_i     (op_pop)
  );

  bces_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .op_valid_i  (op_valid),
    .op_pop_o    (op_pop),
    .res_o       (out_ch.data),
    .res_valid_o (out_ch.valid),
    .res_ready_i (out_ch.ready)
  );

  // The back end never pops an empty queue.
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, op_pop && !op_valid, "pop from empty queue")
  // A result never carries both a read and a write.
  `ASSERT_NEVER(a_rd_wr, clk_i, rst_ni,
    out_ch.valid && out_ch.data.mem_read && out_ch.data.mem_write, "read and write")
  // The back end pops no new word while a result still waits.
  `ASSERT_PROP(a_pop_out, clk_i, rst_ni, op_pop |-> !out_ch.valid, "pop with result pending")
endmodule

/* verif/beta_cpu_execute_step_unit_tb.sv */
// Testbench for the Beta execute unit: directed table, then random programs.
module beta_cpu_execute_step_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bces_pkg::*;

  localparam int unsigned NumRandom = 1950;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam logic [5:0] CmdIllegal = 6'd33;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bces_if #(.T(item_t)) in_ch ();
  bces_if #(.T(res_t))  out_ch ();

  beta_cpu_execute_step_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow architectural state of the processor.
  logic [31:0] shadow_pc;
  logic [31:0] shadow_regs [32];
  logic        shadow_halt;
  logic        shadow_clk_pend;

  res_t   expected_words [$];
  int     mismatches = 0;
  int     cycles = 0;
  bit     no_idle = 1'b0;
  bit     long_hold = 1'b0;
  bit     stim_done = 1'b0;

  // One directed row: the word plus an optional typed-in result.
  typedef struct {
    item_t word;
    bit    has_fixed;
    res_t  fixed;
  } row_t;
  row_t directed_rows [$];

  function automatic logic [31:0] reg_read(logic [4:0] idx);
    return (idx == ZeroReg) ? 32'd0 : shadow_regs[idx];
  endfunction

  function automatic void reg_write(logic [4:0] idx, logic [31:0] val);
    if (idx != ZeroReg) shadow_regs[idx] = val;
  endfunction

  function automatic logic [31:0] alu_result(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    logic signed [31:0] sa;
    logic signed [31:0] sb;
    sa = a;
    sb = b;
    case (op)
      AluAdd:   return a + b;
      AluAnd:   return a & b;
      AluMul:   return a * b;
      AluDiv: begin
        if (b == 0) return 32'd0;
        if (a == SuperBit && b == 32'hFFFF_FFFF) return SuperBit;
        return sa / sb;
      end
      AluOr:    return a | b;
      AluShl:   return a << b[4:0];
      AluShr:   return a >> b[4:0];
      AluSra:   return sa >>> b[4:0];
      AluSub:   return a - b;
      AluXor:   return a ^ b;
      AluCmpeq: return {31'd0, a == b};
      AluCmple: return {31'd0, sa <= sb};
      default:  return {31'd0, sa < sb};
    endcase
  endfunction

  // Executes one word against the shadow state and returns the result.
  function automatic res_t execute_word(item_t w);
    res_t r;
    logic [31:0] pc;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] imm;
    logic [31:0] mask;
    logic [31:0] old;
    logic [31:0] vec;
    bit illegal;
    r = '0;
    illegal = 1'b0;
    if (shadow_halt) begin
      r.next_pc = shadow_pc;
      r.halted = 1'b1;
      return r;
    end
    if (w.clk_irq) shadow_clk_pend = 1'b1;
    imm = {{16{w.immediate[15]}}, w.immediate};
    pc = shadow_pc + 32'd4;
    a = reg_read(w.src_a);
    if (w.command <= CmdAluLast) begin
      b = w.command[0] ? imm : reg_read(w.src_b);
      reg_write(w.dest_c, alu_result(4'(w.command >> 1), a, b));
    end else if (w.command == CmdJmp || w.command == CmdBt || w.command == CmdBf) begin
      mask = PcMaskUser | (pc & SuperBit);
      old = pc;
      if (w.command == CmdJmp) pc = a & mask;
      else if ((w.command == CmdBt) == (a != 0)) pc = (pc + (imm << 2)) & mask;
      reg_write(w.dest_c, old);
    end else if (w.command == CmdLd) begin
      r.mem_read = 1'b1;
      r.mem_addr = a + imm;
      reg_write(w.dest_c, w.load_word);
    end else if (w.command == CmdSt) begin
      r.mem_write = 1'b1;
      r.mem_addr = a + imm;
      r.mem_wdata = reg_read(w.dest_c);
    end else if (w.command == CmdLdr) begin
      r.mem_read = 1'b1;
      r.mem_addr = pc + (imm << 2);
      reg_write(w.dest_c, w.load_word);
    end else if (w.command == CmdCallout && pc[31]) begin
      if (w.immediate == CallHalt) shadow_halt = 1'b1;
      else if (w.immediate == CallRdChr) reg_write(5'd0, {24'd0, w.char_in});
      else if (w.immediate == CallWrChr) begin
        r.char_out_valid = 1'b1;
        r.char_out = 8'(reg_read(5'd0));
      end
    end else begin
      illegal = 1'b1;
    end
    if (illegal) begin
      reg_write(XpReg, pc);
      pc = VecIllop;
    end
    if ((shadow_clk_pend || w.kbd_irq) && !pc[31]) begin
      if (shadow_clk_pend) begin
        shadow_clk_pend = 1'b0;
        vec = VecClk;
      end else begin
        vec = VecKbd;
      end
      reg_write(XpReg, pc + 32'd4);
      pc = vec;
    end
    shadow_pc = pc;
    r.next_pc = pc;
    r.halted = shadow_halt;
    return r;
  endfunction

  function automatic item_t make_word(logic [5:0] cmd, logic [4:0] ra, logic [4:0] rb,
                                      logic [4:0] rc, logic [15:0] imm);
    item_t w;
    w = '0;
    w.command = cmd;
    w.src_a = ra;
    w.src_b = rb;
    w.dest_c = rc;
    w.immediate = imm;
    return w;
  endfunction

  function automatic void add_row(item_t w, bit has_fixed, res_t fixed);
    row_t row;
    row.word = w;
    row.has_fixed = has_fixed;
    row.fixed = fixed;
    directed_rows.push_back(row);
  endfunction

  // Random word: mostly ALU/memory/branches, half with small offsets, some noise.
  function automatic item_t random_word();
    item_t w;
    int unsigned pick;
    w.command = 6'($urandom_range(0, 33));
    if ($urandom_range(0, 30) == 0) w.command = 6'($urandom_range(34, 63));
    w.src_a = 5'($urandom);
    w.src_b = 5'($urandom);
    w.dest_c = 5'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 5) w.immediate = 16'($signed($urandom_range(0, 64)) - 32);
    else w.immediate = 16'($urandom);
    if (w.command == CmdCallout && $urandom_range(0, 3) != 0)
      w.immediate = 16'($urandom_range(1, 3));
    // Halts are rare so that most of the run executes.
    if (w.command == CmdCallout && w.immediate == CallHalt && $urandom_range(0, 7) != 0)
      w.immediate = CallWrChr;
    w.load_word = $urandom;
    w.char_in = 8'($urandom);
    w.clk_irq = ($urandom_range(0, 15) == 0);
    w.kbd_irq = ($urandom_range(0, 15) == 0);
    return w;
  endfunction

  // Sends one word, with random idle bursts before it.
  task automatic send_word(item_t w, bit has_fixed, res_t fixed);
    res_t predicted;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predicted = execute_word(w);
    if (has_fixed && predicted != fixed)
      $display("Directed row disagrees with prediction: %h vs %h", fixed, predicted);
    expected_words.push_back(has_fixed ? fixed : predicted);
  endtask

  // Stimulus.
  initial begin
    res_t fx;
    item_t w;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    for (int i = 0; i < 32; i++) shadow_regs[i] = '0;
    shadow_pc = VecReset;
    shadow_halt = 1'b0;
    shadow_clk_pend = 1'b0;

    // Directed table: extremes, every operation, each special case.
    fx = '0; fx.next_pc = 32'h8000_0004;
    add_row(make_word(6'd1, 5'd31, 5'd0, 5'd1, 16'h7FFF), 1'b1, fx);   // R1 = 32767
    fx.next_pc = 32'h8000_0008;
    add_row(make_word(6'd1, 5'd31, 5'd0, 5'd2, 16'h8000), 1'b1, fx);   // R2 = -32768
    add_row(make_word(6'd1, 5'd1, 5'd0, 5'd31, 16'hFFFF), 1'b0, fx);   // write to R31
    add_row(make_word(6'd11, 5'd2, 5'd0, 5'd3, 16'd16), 1'b0, fx);     // R3 = 0x80000000
    add_row(make_word(6'd7, 5'd3, 5'd0, 5'd4, 16'hFFFF), 1'b0, fx);    // most negative / -1
    add_row(make_word(6'd6, 5'd1, 5'd31, 5'd5, 16'd0), 1'b0, fx);      // divide by zero
    for (int c = 0; c <= 25; c += 2)
      add_row(make_word(6'(c), 5'd2, 5'd1, 5'd6, 16'd0), 1'b0, fx);
    add_row(make_word(6'd15, 5'd3, 5'd0, 5'd7, 16'd33), 1'b0, fx);     // shift count low bits
    add_row(make_word(CmdSt, 5'd2, 5'd0, 5'd1, 16'h8000), 1'b0, fx);
    add_row(make_word(CmdLd, 5'd1, 5'd0, 5'd8, 16'h7FFF), 1'b0, fx);
    add_row(make_word(CmdLdr, 5'd0, 5'd0, 5'd9, 16'hFFFF), 1'b0, fx);
    add_row(make_word(CmdCallout, 5'd0, 5'd0, 5'd0, CallRdChr), 1'b0, fx);
    add_row(make_word(CmdCallout, 5'd0, 5'd0, 5'd0, CallWrChr), 1'b0, fx);
    add_row(make_word(CmdCallout, 5'd0, 5'd0, 5'd0, 16'd7), 1'b0, fx);
    add_row(make_word(CmdBt, 5'd31, 5'd0, 5'd10, 16'd4), 1'b0, fx);
    add_row(make_word(CmdBf, 5'd31, 5'd0, 5'd10, 16'd4), 1'b0, fx);
    // Drop into user mode, then take an illegal op and a user callout.
    add_row(make_word(CmdJmp, 5'd1, 5'd0, 5'd11, 16'd0), 1'b0, fx);
    add_row(make_word(CmdIllegal, 5'd0, 5'd0, 5'd0, 16'd0), 1'b0, fx);
    add_row(make_word(CmdJmp, 5'd1, 5'd0, 5'd11, 16'd0), 1'b0, fx);
    add_row(make_word(CmdCallout, 5'd0, 5'd0, 5'd0, CallHalt), 1'b0, fx);
    add_row(make_word(CmdJmp, 5'd1, 5'd0, 5'd11, 16'd0), 1'b0, fx);
    w = make_word(6'd0, 5'd0, 5'd0, 5'd12, 16'd0);
    w.clk_irq = 1'b1; w.kbd_irq = 1'b1;
    add_row(w, 1'b0, fx);

    @(posedge clk_i);
    @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].has_fixed, directed_rows[i].fixed);

    // Random part; a quarter through, the output stalls for a long stretch.
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 4) long_hold <= 1'b1;
      if (n >= NumRandom - 200) no_idle <= 1'b1;
      w = random_word();
      send_word(w, 1'b0, '0);
    end
    // Halt at the end and check the answer of a halted unit.
    send_word(make_word(CmdCallout, 5'd0, 5'd0, 5'd0, CallHalt), 1'b0, '0);
    send_word(random_word(), 1'b0, '0);
    in_ch.valid <= 1'b0;
    stim_done <= 1'b1;
  end

  // Long receiver hold-off, counted here in cycles.
  initial begin
    wait (long_hold);
    @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Receiver with random stall bursts.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ch.ready <= 1'b0;
      end else if (stall != 0) begin
        stall--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word: %h", out_ch.data);
      end else begin
        want = expected_words.pop_front();
        if (out_ch.data.next_pc !== want.next_pc || out_ch.data.mem_read !== want.mem_read ||
            out_ch.data.mem_write !== want.mem_write ||
            out_ch.data.mem_addr !== want.mem_addr ||
            out_ch.data.mem_wdata !== want.mem_wdata ||
            out_ch.data.char_out_valid !== want.char_out_valid ||
            out_ch.data.char_out !== want.char_out || out_ch.data.halted !== want.halted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: pc %h/%h rd %b/%b wr %b/%b addr %h/%h wd %h/%h cv %b/%b co %h/%h h %b/%b",
                     want.next_pc, out_ch.data.next_pc, want.mem_read, out_ch.data.mem_read,
                     want.mem_write, out_ch.data.mem_write, want.mem_addr, out_ch.data.mem_addr,
                     want.mem_wdata, out_ch.data.mem_wdata, want.char_out_valid,
                     out_ch.data.char_out_valid, want.char_out, out_ch.data.char_out,
                     want.halted, out_ch.data.halted);
        end
      end
    end
  end

  // End of run: drain, settle, then report; or time out.
  initial begin
    wait (stim_done);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/bces_pkg.sv
rtl/core/bces_if.sv
rtl/core/bces_ram.sv
rtl/core/bces_front.sv
rtl/core/bces_div.sv
rtl/core/bces_back.sv
rtl/core/beta_cpu_execute_step_unit.sv
verif/beta_cpu_execute_step_unit_tb.sv
